>>> rtl/kelt_pkg.sv
// Shared definitions for the key edge layout scan-code translator.
// Holds key-space constants, the Latin and Cyrillic scan-code tables and the
// event record passed from the key tracker to the top level. No dependencies.
package kelt_pkg;

   localparam int KEY_COUNT = 256;
   localparam int HOST_KEY_W = 8;
   localparam int CODE_W = 7;
   localparam int STATE_W = 2;   // {held, latched_latin}

   localparam logic [CODE_W-1:0] NO_CODE = '0;

   typedef struct packed {
      logic              valid;    // stage holds a beat
      logic              emit;     // beat produces a result
      logic [CODE_W-1:0] code;
      logic              pressed;
   } evt_type;

   function automatic logic [CODE_W-1:0] latin_code(input logic [HOST_KEY_W-1:0] key);
      logic [CODE_W-1:0] c;
      case (key)
         8'h08: c = 7'o132;  8'h09: c = 7'o026;  8'h0D: c = 7'o153;  8'h0E: c = 7'o166;
         8'h10: c = 7'o105;  8'h14: c = 7'o107;  8'h1B: c = 7'o006;
         8'h20: c = 7'o113;  8'h21: c = 7'o004;  8'h22: c = 7'o151;  8'h23: c = 7'o152;
         8'h24: c = 7'o155;  8'h25: c = 7'o116;  8'h26: c = 7'o154;  8'h27: c = 7'o133;
         8'h28: c = 7'o134;  8'h2D: c = 7'o171;  8'h2E: c = 7'o172;
         8'h30: c = 7'o176;  8'h31: c = 7'o030;  8'h32: c = 7'o031;  8'h33: c = 7'o032;
         8'h34: c = 7'o013;  8'h35: c = 7'o034;  8'h36: c = 7'o035;  8'h37: c = 7'o016;
         8'h38: c = 7'o017;  8'h39: c = 7'o177;
         8'h41: c = 7'o072;  8'h42: c = 7'o076;  8'h43: c = 7'o050;  8'h44: c = 7'o057;
         8'h45: c = 7'o033;  8'h46: c = 7'o047;  8'h47: c = 7'o055;  8'h48: c = 7'o156;
         8'h49: c = 7'o073;  8'h4A: c = 7'o027;  8'h4B: c = 7'o052;  8'h4C: c = 7'o056;
         8'h4D: c = 7'o112;  8'h4E: c = 7'o054;  8'h4F: c = 7'o075;
         8'h50: c = 7'o053;  8'h51: c = 7'o067;  8'h52: c = 7'o074;  8'h53: c = 7'o111;
         8'h54: c = 7'o114;  8'h55: c = 7'o051;  8'h56: c = 7'o137;  8'h57: c = 7'o071;
         8'h58: c = 7'o115;  8'h59: c = 7'o070;  8'h5A: c = 7'o157;  8'h5D: c = 7'o106;
         8'h60: c = 7'o126;  8'h61: c = 7'o127;  8'h62: c = 7'o147;  8'h63: c = 7'o167;
         8'h64: c = 7'o130;  8'h65: c = 7'o150;  8'h66: c = 7'o170;  8'h67: c = 7'o125;
         8'h68: c = 7'o145;  8'h69: c = 7'o165;  8'h6A: c = 7'o025;  8'h6D: c = 7'o005;
         8'h6E: c = 7'o146;  8'h6F: c = 7'o131;
         8'h70: c = 7'o010;  8'h71: c = 7'o011;  8'h72: c = 7'o012;  8'h73: c = 7'o014;
         8'h74: c = 7'o015;  8'h75: c = 7'o172;  8'h76: c = 7'o152;  8'h77: c = 7'o151;
         8'h78: c = 7'o171;  8'h7A: c = 7'o004;  8'h7B: c = 7'o155;
         8'hA2: c = 7'o046;  8'hA3: c = 7'o066;
         8'hBA: c = 7'o174;  8'hBB: c = 7'o110;  8'hBC: c = 7'o117;  8'hBD: c = 7'o175;
         8'hBE: c = 7'o135;  8'hBF: c = 7'o173;
         8'hC0: c = 7'o007;
         8'hDB: c = 7'o036;  8'hDC: c = 7'o136;  8'hDD: c = 7'o037;  8'hDE: c = 7'o077;
         default: c = NO_CODE;
      endcase
      return c;
   endfunction

   function automatic logic [CODE_W-1:0] cyrillic_code(input logic [HOST_KEY_W-1:0] key);
      logic [CODE_W-1:0] c;
      case (key)
         8'h08: c = 7'o132;  8'h09: c = 7'o026;  8'h0D: c = 7'o153;  8'h0E: c = 7'o166;
         8'h10: c = 7'o105;  8'h14: c = 7'o107;  8'h1B: c = 7'o006;
         8'h20: c = 7'o113;  8'h21: c = 7'o004;  8'h22: c = 7'o151;  8'h23: c = 7'o152;
         8'h24: c = 7'o174;  8'h25: c = 7'o116;  8'h26: c = 7'o154;  8'h27: c = 7'o133;
         8'h28: c = 7'o134;  8'h2D: c = 7'o171;  8'h2E: c = 7'o172;
         8'h30: c = 7'o176;  8'h31: c = 7'o030;  8'h32: c = 7'o031;  8'h33: c = 7'o032;
         8'h34: c = 7'o013;  8'h35: c = 7'o034;  8'h36: c = 7'o035;  8'h37: c = 7'o016;
         8'h38: c = 7'o017;  8'h39: c = 7'o177;
         8'h41: c = 7'o047;  8'h42: c = 7'o073;  8'h43: c = 7'o111;  8'h44: c = 7'o071;
         8'h45: c = 7'o051;  8'h46: c = 7'o072;  8'h47: c = 7'o053;  8'h48: c = 7'o074;
         8'h49: c = 7'o036;  8'h4A: c = 7'o075;  8'h4B: c = 7'o056;  8'h4C: c = 7'o057;
         8'h4D: c = 7'o115;  8'h4E: c = 7'o114;  8'h4F: c = 7'o037;
         8'h50: c = 7'o157;  8'h51: c = 7'o027;  8'h52: c = 7'o052;  8'h53: c = 7'o070;
         8'h54: c = 7'o033;  8'h55: c = 7'o055;  8'h56: c = 7'o112;  8'h57: c = 7'o050;
         8'h58: c = 7'o110;  8'h59: c = 7'o054;  8'h5A: c = 7'o067;  8'h5D: c = 7'o106;
         8'h60: c = 7'o126;  8'h61: c = 7'o127;  8'h62: c = 7'o147;  8'h63: c = 7'o167;
         8'h64: c = 7'o130;  8'h65: c = 7'o150;  8'h66: c = 7'o170;  8'h67: c = 7'o125;
         8'h68: c = 7'o145;  8'h69: c = 7'o165;  8'h6A: c = 7'o025;  8'h6D: c = 7'o005;
         8'h6E: c = 7'o146;  8'h6F: c = 7'o131;
         8'h70: c = 7'o010;  8'h71: c = 7'o011;  8'h72: c = 7'o012;  8'h73: c = 7'o014;
         8'h74: c = 7'o015;  8'h75: c = 7'o172;  8'h76: c = 7'o152;  8'h77: c = 7'o151;
         8'h78: c = 7'o171;  8'h7A: c = 7'o004;  8'h7B: c = 7'o174;
         8'hA2: c = 7'o046;  8'hA3: c = 7'o066;
         8'hBA: c = 7'o137;  8'hBB: c = 7'o117;  8'hBC: c = 7'o076;  8'hBD: c = 7'o175;
         8'hBE: c = 7'o077;  8'hBF: c = 7'o173;
         8'hC0: c = 7'o007;
         8'hDB: c = 7'o156;  8'hDC: c = 7'o135;  8'hDD: c = 7'o155;  8'hDE: c = 7'o136;
         default: c = NO_CODE;
      endcase
      return c;
   endfunction

endpackage

>>> rtl/kelt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module kelt_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/kelt_key_tracker.sv
// Per-key state tracker: held/latched-layout memory, valid bits, write-to-read
// forwarding and the translation decision. Uses kelt_pkg and kelt_ram.
module kelt_key_tracker #(
   parameter int KEY_COUNT = kelt_pkg::KEY_COUNT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_load,
   input  logic [kelt_pkg::HOST_KEY_W-1:0]   in_key,
   input  logic                              in_down,
   input  logic                              in_latin,
   input  logic                              advance,
   output kelt_pkg::evt_type                 evt
);

   localparam int KEY_W = $clog2(KEY_COUNT);
   localparam int HW = kelt_pkg::HOST_KEY_W;
   localparam int SW = kelt_pkg::STATE_W;

   logic in_range;
   logic rd_en;
   logic [SW-1:0] rd_data;

   // stage 1 registers
   logic          s1_valid_ff, s1_valid_in;
   logic [HW-1:0] s1_key_ff;
   logic          s1_down_ff;
   logic          s1_latin_ff;
   logic          s1_range_ff;
   logic          s1_vld_ff;

   logic [KEY_COUNT-1:0] vld_ff, vld_in;

   logic             fwd_valid_ff, fwd_valid_in;
   logic [KEY_W-1:0] fwd_addr_ff;
   logic [SW-1:0]    fwd_data_ff;

   logic [KEY_W-1:0] s1_addr;
   logic [SW-1:0]    cur_state;
   logic [SW-1:0]    new_state;
   logic             held;
   logic             changed;
   logic             use_latin;
   logic             wr_en;
   logic [kelt_pkg::CODE_W-1:0] code;

   assign in_range = ({1'b0, in_key} < (HW+1)'(KEY_COUNT));
   assign rd_en    = in_load && in_range;
   assign s1_addr  = s1_key_ff[KEY_W-1:0];

   kelt_ram #(
      .WIDTH (SW),
      .DEPTH (KEY_COUNT)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr),
      .wr_data (new_state),
      .rd_en   (rd_en),
      .rd_addr (in_key[KEY_W-1:0]),
      .rd_data (rd_data)
   );

   // Forwarded entry is the most recent write, so a match is always current.
   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == s1_addr)) begin
         cur_state = fwd_data_ff;
      end else if (s1_vld_ff) begin
         cur_state = rd_data;
      end else begin
         cur_state = '0;
      end
      held      = cur_state[1];
      changed   = s1_range_ff && (s1_down_ff != held);
      use_latin = held ? cur_state[0] : s1_latin_ff;
      new_state = s1_down_ff ? {1'b1, s1_latin_ff} : '0;
      code      = use_latin ? kelt_pkg::latin_code(s1_key_ff)
                            : kelt_pkg::cyrillic_code(s1_key_ff);
      wr_en     = s1_valid_ff && advance && changed;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (in_load) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[s1_addr] = 1'b1;
      end
      fwd_valid_in = fwd_valid_ff || wr_en;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         vld_ff       <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         vld_ff       <= vld_in;
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         s1_key_ff   <= in_key;
         s1_down_ff  <= in_down;
         s1_latin_ff <= in_latin;
         s1_range_ff <= in_range;
         s1_vld_ff   <= in_range ? vld_ff[in_key[KEY_W-1:0]] : 1'b0;
      end
      if (wr_en) begin
         fwd_addr_ff <= s1_addr;
         fwd_data_ff <= new_state;
      end
   end

   assign evt.valid   = s1_valid_ff;
   assign evt.emit    = changed && (code != kelt_pkg::NO_CODE);
   assign evt.code    = code;
   assign evt.pressed = s1_down_ff;

endmodule

>>> rtl/key_edge_layout_scancode_translator.sv
// Key edge layout scan-code translator, top level.
// Depends on kelt_pkg, kelt_key_tracker and kelt_ram.
//
// Usage:
//   req_ channel: one host key report per beat (host_key, host_down,
//   layout_latin). rsp_ channel: zero or one translated event per report
//   (target_code, target_pressed). Reports that do not change a key's held
//   state, keys at or above KEY_COUNT and keys with no table entry give no
//   result beat.
//   A result reaches rsp_ after the state memory read at the accepting edge
//   and the output register; a stall can hold it in between. Throughput:
//   one report per cycle while the output does not stall. Per-key state
//   sits in a 2-bit wide, KEY_COUNT deep memory updated read-modify-write;
//   a write to the key read in the previous cycle is forwarded, so
//   back-to-back reports to the same key need no stall.
//   Reset: all keys read as released with Cyrillic latched (all per-key valid
//   bits are cleared by reset); req_ready is low while reset is high and
//   reports are taken as soon as it falls, with no clearing pass.
//   Stall: when rsp_ready is low and the output register is full, the
//   translate stage holds; req_ready drops only once that stage is also full.
module key_edge_layout_scancode_translator #(
   parameter int KEY_COUNT = kelt_pkg::KEY_COUNT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [kelt_pkg::HOST_KEY_W-1:0]   req_host_key,
   input  logic                              req_host_down,
   input  logic                              req_layout_latin,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [kelt_pkg::CODE_W-1:0]       rsp_target_code,
   output logic                              rsp_target_pressed
);

   kelt_pkg::evt_type evt;
   logic in_load;
   logic advance;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [kelt_pkg::CODE_W-1:0] rsp_code_ff;
   logic                        rsp_pressed_ff;

   assign advance   = evt.valid && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !reset && (!evt.valid || advance);
   assign in_load   = req_valid && req_ready;

   kelt_key_tracker #(
      .KEY_COUNT (KEY_COUNT)
   ) u_tracker (
      .clock    (clock),
      .reset    (reset),
      .in_load  (in_load),
      .in_key   (req_host_key),
      .in_down  (req_host_down),
      .in_latin (req_layout_latin),
      .advance  (advance),
      .evt      (evt)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (advance && evt.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && evt.emit) begin
         rsp_code_ff    <= evt.code;
         rsp_pressed_ff <= evt.pressed;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_target_code    = rsp_code_ff;
   assign rsp_target_pressed = rsp_pressed_ff;

endmodule

>>> tb/tb_key_edge_layout_scancode_translator.sv
`timescale 1ns / 1ps
// Self-checking testbench for key_edge_layout_scancode_translator: directed and
// random key reports with random stalls on both channels. Depends on kelt_pkg.
module tb_key_edge_layout_scancode_translator;

   localparam int CYCLE_LIMIT = 300000;
   localparam int RANDOM_REPORTS = 1826;
   localparam int HOLD_CYCLES = 80;

   typedef struct packed {
      logic [kelt_pkg::CODE_W-1:0] code;
      logic                        pressed;
   } key_event_type;

   // Tracks held/latched layout per key and the events the block still owes.
   class key_event_board;
      bit [kelt_pkg::CODE_W-1:0] latin_scan [256] = '{
         0,0,0,0,0,0,0,0,
         7'o132,7'o026,0,0,0,7'o153,7'o166,0,
         7'o105,0,0,0,7'o107,0,0,0,
         0,0,0,7'o006,0,0,0,0,
         7'o113,7'o004,7'o151,7'o152,7'o155,7'o116,7'o154,7'o133,
         7'o134,0,0,0,0,7'o171,7'o172,0,
         7'o176,7'o030,7'o031,7'o032,7'o013,7'o034,7'o035,7'o016,
         7'o017,7'o177,0,0,0,0,0,0,
         0,7'o072,7'o076,7'o050,7'o057,7'o033,7'o047,7'o055,
         7'o156,7'o073,7'o027,7'o052,7'o056,7'o112,7'o054,7'o075,
         7'o053,7'o067,7'o074,7'o111,7'o114,7'o051,7'o137,7'o071,
         7'o115,7'o070,7'o157,0,0,7'o106,0,0,
         7'o126,7'o127,7'o147,7'o167,7'o130,7'o150,7'o170,7'o125,
         7'o145,7'o165,7'o025,0,0,7'o005,7'o146,7'o131,
         7'o010,7'o011,7'o012,7'o014,7'o015,7'o172,7'o152,7'o151,
         7'o171,0,7'o004,7'o155,0,0,0,0,
         0,0,0,0,0,0,0,0,
         0,0,0,0,0,0,0,0,
         0,0,0,0,0,0,0,0,
         0,0,0,0,0,0,0,0,
         0,0,7'o046,7'o066,0,0,0,0,
         0,0,0,0,0,0,0,0,
         0,0,0,0,0,0,0,0,
         0,0,7'o174,7'o110,7'o117,7'o175,7'o135,7'o173,
         7'o007,0,0,0,0,0,0,0,
         0,0,0,0,0,0,0,0,
         0,0,0,0,0,0,0,0,
         0,0,0,7'o036,7'o136,7'o037,7'o077,0,
         0,0,0,0,0,0,0,0,
         0,0,0,0,0,0,0,0,
         0,0,0,0,0,0,0,0,
         0,0,0,0,0,0,0,0
      };
      bit [kelt_pkg::CODE_W-1:0] cyrillic_scan [256] = '{
         0,0,0,0,0,0,0,0,
         7'o132,7'o026,0,0,0,7'o153,7'o166,0,
         7'o105,0,0,0,7'o107,0,0,0,
         0,0,0,7'o006,0,0,0,0,
         7'o113,7'o004,7'o151,7'o152,7'o174,7'o116,7'o154,7'o133,
         7'o134,0,0,0,0,7'o171,7'o172,0,
         7'o176,7'o030,7'o031,7'o032,7'o013,7'o034,7'o035,7'o016,
         7'o017,7'o177,0,0,0,0,0,0,
         0,7'o047,7'o073,7'o111,7'o071,7'o051,7'o072,7'o053,
         7'o074,7'o036,7'o075,7'o056,7'o057,7'o115,7'o114,7'o037,
         7'o157,7'o027,7'o052,7'o070,7'o033,7'o055,7'o112,7'o050,
         7'o110,7'o054,7'o067,0,0,7'o106,0,0,
         7'o126,7'o127,7'o147,7'o167,7'o130,7'o150,7'o170,7'o125,
         7'o145,7'o165,7'o025,0,0,7'o005,7'o146,7'o131,
         7'o010,7'o011,7'o012,7'o014,7'o015,7'o172,7'o152,7'o151,
         7'o171,0,7'o004,7'o174,0,0,0,0,
         0,0,0,0,0,0,0,0,
         0,0,0,0,0,0,0,0,
         0,0,0,0,0,0,0,0,
         0,0,0,0,0,0,0,0,
         0,0,7'o046,7'o066,0,0,0,0,
         0,0,0,0,0,0,0,0,
         0,0,0,0,0,0,0,0,
         0,0,7'o137,7'o117,7'o076,7'o175,7'o077,7'o173,
         7'o007,0,0,0,0,0,0,0,
         0,0,0,0,0,0,0,0,
         0,0,0,0,0,0,0,0,
         0,0,0,7'o156,7'o135,7'o155,7'o136,0,
         0,0,0,0,0,0,0,0,
         0,0,0,0,0,0,0,0,
         0,0,0,0,0,0,0,0,
         0,0,0,0,0,0,0,0
      };
      bit            held [256];
      bit            latched_latin [256];
      key_event_type pending_events [$];
      int            errors;
      int            reports;
      int            presses;
      int            releases;
      int            silent;

      function void note_report(logic [kelt_pkg::HOST_KEY_W-1:0] key, logic down,
                                logic latin);
         bit                        use_latin;
         bit [kelt_pkg::CODE_W-1:0] code;
         key_event_type             ev;
         reports++;
         if (int'(key) >= kelt_pkg::KEY_COUNT || down == held[key]) begin
            silent++;
            return;
         end
         // release translates with the layout latched at press time
         use_latin = held[key] ? latched_latin[key] : latin;
         held[key] = down;
         latched_latin[key] = down ? latin : 1'b0;
         code = use_latin ? latin_scan[key] : cyrillic_scan[key];
         if (code == kelt_pkg::NO_CODE) begin
            silent++;
            return;
         end
         ev.code = code;
         ev.pressed = down;
         pending_events.push_back(ev);
      endfunction

      task report_mismatch(string msg);
         errors++;
         $display("mismatch: %s", msg);
      endtask

      task check_event(logic [kelt_pkg::CODE_W-1:0] code, logic pressed);
         key_event_type ev;
         if (pending_events.size() == 0) begin
            report_mismatch($sformatf("unexpected beat code %o pressed %b", code, pressed));
            return;
         end
         ev = pending_events.pop_front();
         if (code !== ev.code)
            report_mismatch($sformatf("target_code %o, want %o", code, ev.code));
         if (pressed !== ev.pressed)
            report_mismatch($sformatf("target_pressed %b, want %b", pressed, ev.pressed));
         if (ev.pressed) presses++;
         else releases++;
      endtask
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [kelt_pkg::HOST_KEY_W-1:0] req_host_key = '0;
   logic                            req_host_down = 1'b0;
   logic                            req_layout_latin = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [kelt_pkg::CODE_W-1:0]     rsp_target_code;
   logic                            rsp_target_pressed;

   key_event_board board;
   bit             no_gaps = 1'b0;
   bit             hold_request = 1'b0;
   bit             drv_held [256];
   int             cycle_count = 0;

   logic [kelt_pkg::HOST_KEY_W-1:0] hot_keys [12] = '{
      8'h41, 8'h24, 8'h7B, 8'hBA, 8'hDB, 8'h5A, 8'h08, 8'h39, 8'hC0, 8'h4F, 8'h00, 8'hDE
   };

   key_edge_layout_scancode_translator uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_host_key       (req_host_key),
      .req_host_down      (req_host_down),
      .req_layout_latin   (req_layout_latin),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_target_code    (rsp_target_code),
      .rsp_target_pressed (rsp_target_pressed)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d events outstanding",
                  cycle_count, board.pending_events.size());
         $display("[key_edge_layout_scancode_translator] ERROR");
         $finish;
      end
   end

   // Inputs only move at posedge, so the negedge sees what the next edge takes.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            board.note_report(req_host_key, req_host_down, req_layout_latin);
         if (rsp_valid && rsp_ready)
            board.check_event(rsp_target_code, rsp_target_pressed);
      end
   end

   initial begin : receiver
      int hold_left;
      bit hold_served;
      hold_left = 0;
      hold_served = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_served) begin
            hold_left = HOLD_CYCLES;
            hold_served = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= no_gaps || ($urandom_range(99) >= 24);
         end
      end
   end

   task automatic send_report(input logic [kelt_pkg::HOST_KEY_W-1:0] key,
                              input logic down, input logic latin);
      logic taken;
      while (!no_gaps && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_host_key <= key;
      req_host_down <= down;
      req_layout_latin <= latin;
      drv_held[key] = down;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic run_random(input int target);
      int                              sent;
      int                              pick;
      logic [kelt_pkg::HOST_KEY_W-1:0] key;
      logic [kelt_pkg::HOST_KEY_W-1:0] last_key;
      logic                            down;
      logic                            latin;
      sent = 0;
      last_key = hot_keys[0];
      while (sent < target) begin
         no_gaps = (sent >= 600 && sent < 950);
         if (sent >= 1300) hold_request = 1'b1;
         pick = $urandom_range(99);
         latin = 1'($urandom_range(1));
         if (pick < 15) begin
            key = last_key;               // same key back to back
            down = !drv_held[key];
         end else if (pick < 60) begin
            key = hot_keys[$urandom_range(11)];
            down = !drv_held[key];
         end else if (pick < 75) begin
            key = 8'($urandom_range(255));
            down = !drv_held[key];
         end else if (pick < 88) begin
            key = hot_keys[$urandom_range(11)];
            down = drv_held[key];         // repeat of the current state
         end else begin
            key = 8'($urandom_range(255));
            down = 1'($urandom_range(1));
         end
         last_key = key;
         sent++;
         send_report(key, down, latin);
      end
      no_gaps = 1'b0;
   endtask

   initial begin : main
      board = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // no table entry: state flips but nothing comes out
      send_report(8'h00, 1'b1, 1'b0);
      send_report(8'h00, 1'b0, 1'b0);
      send_report(8'hFF, 1'b1, 1'b1);
      send_report(8'hFF, 1'b0, 1'b1);
      send_report(8'h80, 1'b1, 1'b1);
      send_report(8'h80, 1'b0, 1'b0);
      // release of a key never pressed, then press held twice
      send_report(8'h41, 1'b0, 1'b1);
      send_report(8'h41, 1'b1, 1'b1);
      send_report(8'h41, 1'b1, 1'b0);
      // layout flips while held: release keeps the latched table
      send_report(8'h41, 1'b0, 1'b0);
      send_report(8'h41, 1'b1, 1'b0);
      send_report(8'h41, 1'b0, 1'b1);
      send_report(8'h24, 1'b1, 1'b1);
      send_report(8'h24, 1'b0, 1'b0);
      send_report(8'h7B, 1'b1, 1'b0);
      send_report(8'h7B, 1'b0, 1'b1);
      send_report(8'h08, 1'b1, 1'b0);
      send_report(8'h08, 1'b0, 1'b0);
      send_report(8'h39, 1'b1, 1'b1);
      send_report(8'h39, 1'b0, 1'b1);
      send_report(8'hDE, 1'b1, 1'b0);
      send_report(8'hDE, 1'b0, 1'b1);
      send_report(8'h7F, 1'b1, 1'b1);
      send_report(8'h7F, 1'b0, 1'b0);

      run_random(RANDOM_REPORTS);
      req_valid <= 1'b0;

      while (board.pending_events.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d key reports: %0d press and %0d release events, %0d silent",
               board.reports, board.presses, board.releases, board.silent);
      $display("including a %0d-cycle output stall and a stretch without gaps", HOLD_CYCLES);
      if (board.errors == 0) begin
         $display("[key_edge_layout_scancode_translator] OK");
      end else begin
         $display("%0d mismatches", board.errors);
         $display("[key_edge_layout_scancode_translator] ERROR");
      end
      $finish;
   end

endmodule

>>> key_edge_layout_scancode_translator.f
rtl/kelt_pkg.sv
rtl/kelt_ram.sv
rtl/kelt_key_tracker.sv
rtl/key_edge_layout_scancode_translator.sv
tb/tb_key_edge_layout_scancode_translator.sv
